### sv/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants of the postfix stack evaluator
// Request/response payloads, decoded command format, status codes and the
// symbol decoder used by the front end.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR = 8'h2A;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] symbol;
      logic end_of_expr;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_PUSH,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [3:0] digit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic go;
      logic last;
      logic [1:0] error;
   } stat_type;

   function automatic cmd_type classify(req_type r);
      cmd_type c;
      c.kind = KIND_NOP;
      c.digit = 4'(r.symbol - CHAR_ZERO);
      c.last = r.end_of_expr;
      if (r.symbol inside {[CHAR_ZERO:CHAR_NINE]}) begin
         c.kind = KIND_PUSH;
      end else begin
         case (r.symbol)
            CHAR_PLUS: c.kind = KIND_ADD;
            CHAR_MINUS: c.kind = KIND_SUB;
            CHAR_STAR: c.kind = KIND_MUL;
            default: c.kind = KIND_NOP;
         endcase
      end
      return c;
   endfunction

endpackage

### sv/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module pse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pse_queue.sv
// ----------------------------------------------------------------------------
// pse_queue: small register-based FIFO
// Push/full on the write side, pop/empty on the read side; head is shown
// while empty is low.
// ----------------------------------------------------------------------------
module pse_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### sv/pse_front.sv
// ----------------------------------------------------------------------------
// pse_front: request intake and symbol decode
// Decodes each request into a stack command and queues it for the back end.
// ----------------------------------------------------------------------------
module pse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pse_pkg::req_type req_data,
   output logic             full,
   input  logic             cmd_pop,
   output pse_pkg::cmd_type cmd,
   output logic             cmd_empty
);

   pse_pkg::cmd_type cmd_in;
   logic [$bits(pse_pkg::cmd_type)-1:0] cmd_raw;

   assign cmd_in = pse_pkg::classify(req_data);
   assign cmd = pse_pkg::cmd_type'(cmd_raw);

   pse_queue #(
      .WIDTH($bits(pse_pkg::cmd_type)),
      .DEPTH(pse_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .wdata(cmd_in),
      .full(full),
      .pop(cmd_pop),
      .rdata(cmd_raw),
      .empty(cmd_empty)
   );

endmodule

### sv/pse_back.sv
// ----------------------------------------------------------------------------
// pse_back: stack execution unit
// Top two operands in registers, deeper entries in RAM with a prefetched
// read of the third entry; results go to a small response queue.
// ----------------------------------------------------------------------------
module pse_back #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  pse_pkg::cmd_type  cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output pse_pkg::rsp_type  rsp_data,
   output logic              empty,
   input  logic              pop,
   output pse_pkg::stat_type stat
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [CW-1:0] count_ff, count_in;
   logic [1:0] err_ff, err_in;
   logic [VALUE_WIDTH-1:0] top_ff, top_in, sec_ff, sec_in;
   logic [VALUE_WIDTH-1:0] below, op_res, mul_res, digit_val;
   logic [VALUE_WIDTH-1:0] ram_rd, byp_data_ff;
   logic bypass_ff, bypass_in;
   logic ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic go, mul_busy, out_full, can_op, stack_full, is_op;
   logic rsp_push;
   pse_pkg::rsp_type rsp_in;
   logic [$bits(pse_pkg::rsp_type)-1:0] rsp_raw;

   assign can_op = (count_ff >= CW'(2));
   assign stack_full = (count_ff == CW'(STACK_DEPTH));
   assign is_op = cmd.kind inside {pse_pkg::KIND_ADD, pse_pkg::KIND_SUB, pse_pkg::KIND_MUL};
   assign go = ~cmd_empty & ~mul_busy & ~(cmd.last & out_full);
   assign cmd_pop = go;
   assign digit_val = VALUE_WIDTH'(cmd.digit);
   assign below = bypass_ff ? byp_data_ff : ram_rd;
   assign ram_wa = AW'(count_ff - CW'(2));

   generate
      if (VALUE_WIDTH > 32) begin : g_mul_split
         logic [63:0] a_wide, b_wide, pll_ff;
         logic [31:0] pmid_ff;
         logic phase_ff, phase_in;

         assign a_wide = 64'(sec_ff);
         assign b_wide = 64'(top_ff);
         assign mul_busy = ~cmd_empty & (cmd.kind == pse_pkg::KIND_MUL) & can_op & ~phase_ff;
         assign mul_res = VALUE_WIDTH'(pll_ff + {pmid_ff, 32'b0});

         always_comb begin
            phase_in = phase_ff;
            if (mul_busy) begin
               phase_in = 1'b1;
            end else if (go) begin
               phase_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               phase_ff <= 1'b0;
            end else begin
               phase_ff <= phase_in;
            end
         end

         always_ff @(posedge clock) begin
            if (mul_busy) begin
               pll_ff <= {32'b0, a_wide[31:0]} * {32'b0, b_wide[31:0]};
               pmid_ff <= a_wide[31:0] * b_wide[63:32] + a_wide[63:32] * b_wide[31:0];
            end
         end
      end else begin : g_mul_direct
         assign mul_busy = 1'b0;
         assign mul_res = sec_ff * top_ff;
      end
   endgenerate

   always_comb begin
      case (cmd.kind)
         pse_pkg::KIND_ADD: op_res = sec_ff + top_ff;
         pse_pkg::KIND_SUB: op_res = sec_ff - top_ff;
         default: op_res = mul_res;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      err_in = err_ff;
      top_in = top_ff;
      sec_in = sec_ff;
      ram_we = 1'b0;
      rsp_push = 1'b0;
      rsp_in = '0;
      if (go) begin
         if (cmd.kind == pse_pkg::KIND_PUSH) begin
            if (stack_full) begin
               if (err_ff == pse_pkg::ST_OK) begin
                  err_in = pse_pkg::ST_OVERFLOW;
               end
            end else begin
               ram_we = can_op;
               sec_in = top_ff;
               top_in = digit_val;
               count_in = count_ff + 1'b1;
            end
         end else if (is_op) begin
            if (!can_op) begin
               if (err_ff == pse_pkg::ST_OK) begin
                  err_in = pse_pkg::ST_UNDERFLOW;
               end
            end else begin
               top_in = op_res;
               sec_in = below;
               count_in = count_ff - 1'b1;
            end
         end
         if (cmd.last) begin
            rsp_push = 1'b1;
            rsp_in.value = (count_in != '0) ? 32'($signed(top_in)) : '0;
            if (err_in != pse_pkg::ST_OK) begin
               rsp_in.status = err_in;
            end else if (count_in == '0) begin
               rsp_in.status = pse_pkg::ST_EMPTY;
            end else begin
               rsp_in.status = pse_pkg::ST_OK;
            end
            count_in = '0;
            err_in = pse_pkg::ST_OK;
         end
      end
      ram_ra = (count_in >= CW'(3)) ? AW'(count_in - CW'(3)) : '0;
      bypass_in = ram_we && (ram_wa == ram_ra);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff <= pse_pkg::ST_OK;
         bypass_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         err_ff <= err_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      sec_ff <= sec_in;
      byp_data_ff <= sec_ff;
   end

   pse_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(STACK_DEPTH)
   ) u_stack_ram (
      .clock(clock),
      .wr_en(ram_we),
      .wr_addr(ram_wa),
      .wr_data(sec_ff),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   pse_queue #(
      .WIDTH($bits(pse_pkg::rsp_type)),
      .DEPTH(pse_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .wdata(rsp_in),
      .full(out_full),
      .pop(pop),
      .rdata(rsp_raw),
      .empty(empty)
   );

   assign rsp_data = pse_pkg::rsp_type'(rsp_raw);

   assign stat.go = go;
   assign stat.last = cmd.last;
   assign stat.error = err_ff;

endmodule

### sv/postfix_stack_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_unit: postfix expression evaluator
// One ASCII symbol per request; digits push, + - * combine the top two
// operands; the request marked last returns the top value and a status.
//
// channel   ports                      dir  payload
// request   push / full / req_data     in   pse_pkg::req_type
// response  empty / pop / rsp_data     out  pse_pkg::rsp_type
//
// One request per cycle through the execution stage unless it stalls; '*' holds
// the stage for the split multiplier when VALUE_WIDTH exceeds 32.
// A response is queued as its last request executes.
// Synchronous reset empties both queues and the stack; no RAM clear needed.
// Stalls on pop only hold back last-flagged requests once the response
// queue fills.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pse_pkg::req_type req_data,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output pse_pkg::rsp_type rsp_data
);

   pse_pkg::cmd_type cmd;
   logic cmd_empty, cmd_pop;
   pse_pkg::stat_type stat;

   pse_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .cmd_pop(cmd_pop),
      .cmd(cmd),
      .cmd_empty(cmd_empty)
   );

   pse_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .cmd_empty(cmd_empty),
      .cmd_pop(cmd_pop),
      .rsp_data(rsp_data),
      .empty(empty),
      .pop(pop),
      .stat(stat)
   );

   a_reset_idle: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not empty after reset");

   a_last_clears_error: assert property (@(posedge clock) disable iff (reset)
      (stat.go && stat.last) |=> (stat.error == pse_pkg::ST_OK))
      else $error("error code not cleared after last request");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (stat.go && stat.last) |=> !empty)
      else $error("no response queued after last request");

   a_empty_value_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.status == pse_pkg::ST_EMPTY)) |-> (rsp_data.value == 32'sd0))
      else $error("empty-stack response with non-zero value");

endmodule

### tb/tb_postfix_stack_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator_unit: self-checking bench for the postfix evaluator
// Streams ASCII symbols through the request queue and predicts each result
// with a local stack model. Responses are checked field by field in order.
// Directed expressions cover every operator, sign, underflow, overflow and
// an empty stack at end. Random expressions follow: mostly well-formed, with
// deep overflow runs and noise. Both sides stall at random in two of three phases.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator_unit;

   localparam int STACK_LIMIT = 16;
   localparam int TARGET_ITEMS = 1100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   pse_pkg::req_type req_data = '0;
   pse_pkg::rsp_type rsp_data;

   pse_pkg::req_type pending_reqs[$];
   pse_pkg::rsp_type expected_results[$];
   pse_pkg::rsp_type predicted;

   logic [31:0] eval_stack [STACK_LIMIT];
   int eval_depth = 0;
   logic [1:0] eval_error = pse_pkg::ST_OK;

   int total_reqs = 0;
   int counted_items = 0;
   int accepted_count = 0;
   int fail_count = 0;
   int send_idle_pct;
   int recv_idle_pct;

   postfix_stack_evaluator_unit dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_data(req_data),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   assign send_idle_pct = (accepted_count < total_reqs / 3) ? 14 :
                          (accepted_count < 2 * total_reqs / 3) ? 52 : 0;
   assign recv_idle_pct = (accepted_count < total_reqs / 3) ? 52 :
                          (accepted_count < 2 * total_reqs / 3) ? 14 : 0;

   function automatic bit is_active(logic [7:0] s);
      return (s >= pse_pkg::CHAR_ZERO && s <= pse_pkg::CHAR_NINE) ||
             s == pse_pkg::CHAR_PLUS || s == pse_pkg::CHAR_MINUS ||
             s == pse_pkg::CHAR_STAR;
   endfunction

   // returns 1 when the symbol closes an expression and res holds its result
   function automatic bit eval_symbol(input pse_pkg::req_type r,
                                      output pse_pkg::rsp_type res);
      logic [31:0] top_v;
      logic [31:0] second_v;
      res = '0;
      if (r.symbol >= pse_pkg::CHAR_ZERO && r.symbol <= pse_pkg::CHAR_NINE) begin
         if (eval_depth >= STACK_LIMIT) begin
            if (eval_error == pse_pkg::ST_OK) eval_error = pse_pkg::ST_OVERFLOW;
         end else begin
            eval_stack[eval_depth] = 32'(r.symbol - pse_pkg::CHAR_ZERO);
            eval_depth++;
         end
      end else if (r.symbol == pse_pkg::CHAR_PLUS || r.symbol == pse_pkg::CHAR_MINUS ||
                   r.symbol == pse_pkg::CHAR_STAR) begin
         if (eval_depth < 2) begin
            if (eval_error == pse_pkg::ST_OK) eval_error = pse_pkg::ST_UNDERFLOW;
         end else begin
            top_v = eval_stack[eval_depth - 1];
            second_v = eval_stack[eval_depth - 2];
            eval_depth--;
            case (r.symbol)
               pse_pkg::CHAR_PLUS: eval_stack[eval_depth - 1] = second_v + top_v;
               pse_pkg::CHAR_MINUS: eval_stack[eval_depth - 1] = second_v - top_v;
               default: eval_stack[eval_depth - 1] = second_v * top_v;
            endcase
         end
      end
      if (!r.end_of_expr) return 1'b0;
      res.value = (eval_depth > 0) ? eval_stack[eval_depth - 1] : 32'd0;
      if (eval_error != pse_pkg::ST_OK) res.status = eval_error;
      else if (eval_depth == 0) res.status = pse_pkg::ST_EMPTY;
      else res.status = pse_pkg::ST_OK;
      eval_depth = 0;
      eval_error = pse_pkg::ST_OK;
      return 1'b1;
   endfunction

   function automatic void add_req(logic [7:0] s, logic last);
      pse_pkg::req_type r;
      r.symbol = s;
      r.end_of_expr = last;
      pending_reqs.push_back(r);
      counted_items++;
   endfunction

   function automatic logic [7:0] pick_ignored();
      logic [7:0] s;
      do s = 8'($urandom_range(255)); while (is_active(s));
      return s;
   endfunction

   function automatic logic [7:0] pick_operator();
      int k;
      k = $urandom_range(3);
      if (k == 0) return pse_pkg::CHAR_PLUS;
      if (k == 1) return pse_pkg::CHAR_MINUS;
      return pse_pkg::CHAR_STAR;
   endfunction

   task automatic add_expr(string s);
      for (int i = 0; i < s.len(); i++) add_req(s[i], i == s.len() - 1);
   endtask

   task automatic add_wellformed();
      int depth;
      int pushed;
      int operands;
      int max_depth;
      max_depth = ($urandom_range(7) == 0) ? STACK_LIMIT : $urandom_range(2, 6);
      operands = ($urandom_range(7) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 10);
      depth = 0;
      pushed = 0;
      while (pushed < operands || depth > 1) begin
         if (pushed < operands &&
             (depth < 2 || (depth < max_depth && $urandom_range(1) == 1))) begin
            add_req(8'(pse_pkg::CHAR_ZERO + $urandom_range(9)), 1'b0);
            pushed++;
            depth++;
         end else begin
            add_req(pick_operator(), 1'b0);
            depth--;
         end
         if ($urandom_range(15) == 0) add_req(pick_ignored(), 1'b0);
      end
      if ($urandom_range(7) == 0) add_req(pick_ignored(), 1'b1);
      else pending_reqs[$].end_of_expr = 1'b1;
   endtask

   task automatic add_overflow_run();
      int n;
      n = $urandom_range(15, 20);
      repeat (n) add_req(8'(pse_pkg::CHAR_ZERO + $urandom_range(9)), 1'b0);
      repeat ($urandom_range(0, 18)) add_req(pick_operator(), 1'b0);
      pending_reqs[$].end_of_expr = 1'b1;
   endtask

   task automatic add_noise();
      int n;
      int k;
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         if (k < 4) add_req(8'(pse_pkg::CHAR_ZERO + $urandom_range(9)), i == n - 1);
         else if (k < 7) add_req(pick_operator(), i == n - 1);
         else add_req(8'($urandom_range(255)), i == n - 1);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            if (eval_symbol(req_data, predicted)) expected_results.push_back(predicted);
            accepted_count <= accepted_count + 1;
         end
         if (!push || !full) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               push <= 1'b1;
               req_data <= pending_reqs.pop_front();
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pse_pkg::rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response value=%0d status=%0d",
                        $realtime, rsp_data.value, rsp_data.status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.value !== want.value) begin
                  $display("%0t: value mismatch expected=%0d actual=%0d",
                           $realtime, want.value, rsp_data.value);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch expected=%0d actual=%0d",
                           $realtime, want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      int k;
      add_expr("12+");
      add_expr("39-");
      add_expr("98*");
      add_expr("+");
      add_expr("5+3");
      add_req(8'hFF, 1'b1);
      add_req(8'h00, 1'b1);
      add_expr("09999999999999999*");
      while (counted_items < TARGET_ITEMS) begin
         k = $urandom_range(19);
         if (k < 15) add_wellformed();
         else if (k < 17) add_overflow_run();
         else add_noise();
      end
      total_reqs = pending_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (accepted_count < total_reqs || expected_results.size() > 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("postfix_stack_evaluator_unit verification clean");
      end else begin
         $display("postfix_stack_evaluator_unit verification failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("postfix_stack_evaluator_unit verification failed");
      $finish;
   end

endmodule
